// ----- hw/rtl/hfc_pkg.sv -----
// Shared types, constants and the CRC-8 step function of the HDLC frame checker.
// No dependencies; hfc_deframe, hfc_out_reg and the top level import this package.
`timescale 1ns / 1ps

package hfc_pkg;

	localparam int NUM_ADDR = 4;
	localparam int ADDR_IDX_W = $clog2(NUM_ADDR);

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [7:0] CTRL_BYTE = 8'h03;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_ADDR = 2'd1,
		PH_CTRL = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_START = 3'd1,
		ST_BAD_ADDR = 3'd2,
		ST_BAD_CTRL = 3'd3,
		ST_CRC_ERR = 3'd4,
		ST_TOO_LONG = 3'd5
	} status_t;

	typedef logic [NUM_ADDR-1:0][7:0] addr_set_t;

	typedef struct packed {
		logic kind;
		logic [7:0] payload;
		status_t status;
		logic frame_end;
	} res_t;

	// Reflected CRC-8 (Maxim), one byte per call: eight shift/xor steps.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/hfc_if.sv -----
// Valid/ready channel interfaces of the HDLC frame checker: raw bytes in, results out.
// No dependencies.
`timescale 1ns / 1ps

interface hfc_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface hfc_result_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [7:0] payload_byte;
	logic [2:0] frame_status;
	logic frame_end;

	modport source(output valid, output result_kind, output payload_byte,
		output frame_status, output frame_end, input ready);
	modport sink(input valid, input result_kind, input payload_byte,
		input frame_status, input frame_end, output ready);
endinterface

// ----- hw/rtl/hfc_deframe.sv -----
// Deframer state and per-byte decision logic: flag hunt, address/control check,
// destuffing, hold-back of the last byte and CRC-8 check. Depends on hfc_pkg.
`timescale 1ns / 1ps

module hfc_deframe #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] rx_byte,
	input  hfc_pkg::addr_set_t addr,
	output logic res_valid,
	output hfc_pkg::res_t res
);
	import hfc_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

	phase_t phase_q, phase_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] held_q, held_d;
	logic held_valid_q, held_valid_d;
	logic esc_q, esc_d;
	logic [POS_W-1:0] pos_q, pos_d;

	logic [7:0] crc_in;
	logic [7:0] crc_next;
	logic addr_hit;
	logic is_flag;
	logic [7:0] data_val;
	logic data_emit;

	// One shared CRC step: held byte in payload, incoming byte in header
	assign crc_in = (phase_q == PH_DATA) ? held_q : rx_byte;
	assign crc_next = crc8_update(crc_q, crc_in);
	assign is_flag = (rx_byte == FLAG_BYTE);

	always_comb begin
		addr_hit = 1'b0;
		for (int i = 0; i < NUM_ADDR; i++) begin
			if (rx_byte == addr[i]) addr_hit = 1'b1;
		end
	end

	// Destuffed value of a payload byte and whether it enters the hold register
	always_comb begin
		data_val = rx_byte;
		data_emit = 1'b1;
		if (esc_q) begin
			data_val = rx_byte ^ ESC_XOR;
		end else if (rx_byte == ESC_BYTE) begin
			data_emit = 1'b0;
		end
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		crc_d = crc_q;
		held_d = held_q;
		held_valid_d = held_valid_q;
		esc_d = esc_q;
		pos_d = pos_q;
		case (phase_q)
			PH_ADDR: begin
				if (is_flag) begin
					phase_d = PH_ADDR;
					crc_d = CRC_INIT;
					pos_d = POS_ONE;
				end else if (!addr_hit) begin
					phase_d = PH_HUNT;
					crc_d = CRC_INIT;
					pos_d = '0;
				end else begin
					phase_d = PH_CTRL;
					crc_d = crc_next;
					pos_d = pos_q + POS_ONE;
				end
			end
			PH_CTRL: begin
				if (rx_byte != CTRL_BYTE) begin
					phase_d = PH_HUNT;
					crc_d = CRC_INIT;
					pos_d = '0;
				end else begin
					phase_d = PH_DATA;
					crc_d = crc_next;
					pos_d = pos_q + POS_ONE;
				end
			end
			PH_DATA: begin
				if (is_flag) begin
					phase_d = PH_ADDR;
					crc_d = CRC_INIT;
					held_d = '0;
					held_valid_d = 1'b0;
					esc_d = 1'b0;
					pos_d = POS_ONE;
				end else if (pos_q >= MAX_POS) begin
					phase_d = PH_HUNT;
					crc_d = CRC_INIT;
					held_d = '0;
					held_valid_d = 1'b0;
					esc_d = 1'b0;
					pos_d = '0;
				end else begin
					pos_d = pos_q + POS_ONE;
					esc_d = !esc_q && (rx_byte == ESC_BYTE);
					if (data_emit) begin
						if (held_valid_q) crc_d = crc_next;
						held_d = data_val;
						held_valid_d = 1'b1;
					end
				end
			end
			default: begin
				phase_d = is_flag ? PH_ADDR : PH_HUNT;
				crc_d = CRC_INIT;
				pos_d = is_flag ? POS_ONE : '0;
			end
		endcase
	end

	// Result of the current byte
	always_comb begin
		res_valid = 1'b0;
		res = '{kind: KIND_STATUS, payload: 8'h00, status: ST_OK, frame_end: 1'b0};
		case (phase_q)
			PH_ADDR: begin
				if (!is_flag && !addr_hit) begin
					res_valid = 1'b1;
					res.status = ST_BAD_ADDR;
				end
			end
			PH_CTRL: begin
				if (rx_byte != CTRL_BYTE) begin
					res_valid = 1'b1;
					res.status = ST_BAD_CTRL;
				end
			end
			PH_DATA: begin
				if (is_flag) begin
					res_valid = 1'b1;
					res.frame_end = 1'b1;
					res.status = (held_valid_q && !esc_q && held_q == crc_q) ? ST_OK : ST_CRC_ERR;
				end else if (pos_q >= MAX_POS) begin
					res_valid = 1'b1;
					res.status = ST_TOO_LONG;
				end else if (data_emit && held_valid_q) begin
					res_valid = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.payload = held_q;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q <= CRC_INIT;
			held_q <= '0;
			held_valid_q <= 1'b0;
			esc_q <= 1'b0;
			pos_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			crc_q <= crc_d;
			held_q <= held_d;
			held_valid_q <= held_valid_d;
			esc_q <= esc_d;
			pos_q <= pos_d;
		end
	end

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (pos_q == '0 && !held_valid_q && !esc_q))
		else $error("hunt state carries frame context");
	a_held_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (phase_q == PH_DATA))
		else $error("held byte outside payload");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MAX_POS)
		else $error("byte position past frame limit");
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_PAYLOAD) |-> (res.status == ST_OK && !res.frame_end))
		else $error("payload result carries status");

endmodule

// ----- hw/rtl/hfc_out_reg.sv -----
// Result register of the HDLC frame checker, driving the result channel.
// Depends on hfc_pkg and hfc_if.
`timescale 1ns / 1ps

module hfc_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  hfc_pkg::res_t res,
	output logic can_load,
	hfc_result_if.source result
);
	import hfc_pkg::*;

	logic valid_q;
	res_t data_q;

	// Free when empty or when the held request leaves this cycle
	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) data_q <= res;
	end

	assign result.valid = valid_q;
	assign result.result_kind = data_q.kind;
	assign result.payload_byte = data_q.payload;
	assign result.frame_status = data_q.status;
	assign result.frame_end = data_q.frame_end;

endmodule

// ----- hw/rtl/hdlc_frame_checker_crc8.sv -----
// HDLC receive deframer with CRC-8 check: top level with input register and config.
// Depends on hfc_pkg, hfc_if, hfc_deframe and hfc_out_reg.
//
// Use: raw line bytes enter on the rx channel, one request per byte. Each byte
// yields zero or one request on the result channel: a destuffed payload byte
// (result_kind 0, passed on one byte late so the last byte is held as the CRC)
// or a frame status (result_kind 1; frame_end 1 when given by a closing flag).
// The four accepted address bytes are written on cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Path: an accepted byte is decided while it sits in the input register, and its
// result is loaded into the result register, which presents it (input register
// plus result register).
// Throughput: one byte per cycle while the result channel does not stall, as the CRC-8
// byte and state updates between the input and result registers are combinational.
// Reset: the deframer hunts for an opening flag, CRC is 0xFF, addresses are 0,
// no result is pending.
// Stall: a waiting result holds in the result register; the next byte stays in
// the input register while it has a result and cannot move, and rx.ready drops.
`timescale 1ns / 1ps

module hdlc_frame_checker_crc8 #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic clk,
	input  logic arst_n,
	hfc_byte_if.sink rx,
	hfc_result_if.source result,
	input  logic cfg_we,
	input  logic [hfc_pkg::ADDR_IDX_W-1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import hfc_pkg::*;

	addr_set_t addr_q;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic res_valid;
	res_t res;
	logic can_load;

	// Address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cfg_we) begin
			addr_q[cfg_index] <= cfg_data;
		end
	end

	// Input register: the byte moves on unless its result finds the output full
	assign advance = valid_s1 && (!res_valid || can_load);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) byte_s1 <= rx.rx_byte;
	end

	hfc_deframe #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_deframe (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.rx_byte(byte_s1),
		.addr(addr_q),
		.res_valid(res_valid),
		.res(res)
	);

	hfc_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && res_valid),
		.res(res),
		.can_load(can_load),
		.result(result)
	);

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid && !can_load) |=> (valid_s1 && $stable(byte_s1)))
		else $error("blocked byte left the input register");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("empty input register refuses a byte");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |=> result.valid)
		else $error("result not presented after load");

endmodule
